[rtl/ucr_pkg.sv]
`timescale 1ns / 1ps
// ucr_pkg: shared types, codes and descriptor contents for the endpoint-0 responder
// no dependencies; imported by the responder core

package ucr_pkg;

  // event codes carried in the opcode field
  localparam logic [2:0] OpSetup    = 3'd0;
  localparam logic [2:0] OpIn       = 3'd1;
  localparam logic [2:0] OpOut      = 3'd2;
  localparam logic [2:0] OpBusReset = 3'd3;

  // handshake codes
  localparam logic [1:0] InAck   = 2'd0;
  localparam logic [1:0] InNak   = 2'd1;
  localparam logic [1:0] InStall = 2'd2;
  localparam logic       OutAck   = 1'b0;
  localparam logic       OutStall = 1'b1;

  // standard request codes
  localparam logic [7:0] ReqGetStatus    = 8'd0;
  localparam logic [7:0] ReqClearFeature = 8'd1;
  localparam logic [7:0] ReqSetAddress   = 8'd5;
  localparam logic [7:0] ReqGetDesc      = 8'd6;
  localparam logic [7:0] ReqGetConfig    = 8'd8;
  localparam logic [7:0] ReqSetConfig    = 8'd9;
  localparam logic [7:0] ReqGetInterface = 8'd10;
  localparam logic [7:0] NoRequest       = 8'hFF;

  localparam logic [7:0] TypeClassMask   = 8'h60;
  localparam logic [7:0] TypeRecipMask   = 8'h1F;
  localparam logic [7:0] RecipEndpoint   = 8'h02;
  localparam logic [7:0] EpBulkIn        = 8'h82;
  localparam logic [7:0] EpBulkOut       = 8'h02;

  // descriptor types and string indexes
  localparam logic [7:0] DescDevice = 8'd1;
  localparam logic [7:0] DescConfig = 8'd2;
  localparam logic [7:0] DescString = 8'd3;
  localparam logic [7:0] StrLang    = 8'd0;
  localparam logic [7:0] StrMfr     = 8'd1;
  localparam logic [7:0] StrProd    = 8'd2;

  localparam logic [6:0] LenCap     = 7'h7F;
  localparam logic [6:0] SetupLen   = 7'd8;

  // descriptor store layout
  localparam int unsigned RomSize   = 80;
  localparam int unsigned RomAw     = $clog2(RomSize);
  localparam logic [6:0] DevBase    = 7'd0;
  localparam logic [6:0] DevLen     = 7'd18;
  localparam logic [6:0] CfgBase    = 7'd18;
  localparam logic [6:0] CfgLen     = 7'd32;
  localparam logic [6:0] LangBase   = 7'd50;
  localparam logic [6:0] LangLen    = 7'd4;
  localparam logic [6:0] MfrBase    = 7'd54;
  localparam logic [6:0] MfrLen     = 7'd14;
  localparam logic [6:0] ProdBase   = 7'd68;
  localparam logic [6:0] ProdLen    = 7'd12;
  // max packet size byte of the device descriptor, set from the top-level parameter
  localparam logic [6:0] DevMaxPktIdx = 7'd7;

  function automatic logic [6:0] min7(input logic [6:0] a, input logic [6:0] b);
    min7 = (a < b) ? a : b;
  endfunction

  // initial descriptor contents; the max packet entry reads as zero here
  function automatic logic [7:0] rom_byte(input logic [6:0] idx);
    logic [7:0] b;
    case (idx)
      7'd0:  b = 8'h12; 7'd1:  b = 8'h01; 7'd2:  b = 8'h10; 7'd3:  b = 8'h01;
      7'd4:  b = 8'hFF; 7'd5:  b = 8'h80; 7'd6:  b = 8'h55; 7'd7:  b = 8'h00;
      7'd8:  b = 8'h62; 7'd9:  b = 8'h13; 7'd10: b = 8'h32; 7'd11: b = 8'h55;
      7'd12: b = 8'h00; 7'd13: b = 8'h01; 7'd14: b = 8'h01; 7'd15: b = 8'h02;
      7'd16: b = 8'h00; 7'd17: b = 8'h01;
      7'd18: b = 8'h09; 7'd19: b = 8'h02; 7'd20: b = 8'h20; 7'd21: b = 8'h00;
      7'd22: b = 8'h01; 7'd23: b = 8'h01; 7'd24: b = 8'h00; 7'd25: b = 8'h80;
      7'd26: b = 8'h32;
      7'd27: b = 8'h09; 7'd28: b = 8'h04; 7'd29: b = 8'h00; 7'd30: b = 8'h00;
      7'd31: b = 8'h02; 7'd32: b = 8'h06; 7'd33: b = 8'h80; 7'd34: b = 8'h55;
      7'd35: b = 8'h00;
      7'd36: b = 8'h07; 7'd37: b = 8'h05; 7'd38: b = 8'h82; 7'd39: b = 8'h02;
      7'd40: b = 8'h40; 7'd41: b = 8'h00; 7'd42: b = 8'h00;
      7'd43: b = 8'h07; 7'd44: b = 8'h05; 7'd45: b = 8'h02; 7'd46: b = 8'h02;
      7'd47: b = 8'h40; 7'd48: b = 8'h00; 7'd49: b = 8'h00;
      7'd50: b = 8'h04; 7'd51: b = 8'h03; 7'd52: b = 8'h09; 7'd53: b = 8'h04;
      7'd54: b = 8'h0E; 7'd55: b = 8'h03; 7'd56: b = 8'h55; 7'd57: b = 8'h00;
      7'd58: b = 8'h53; 7'd59: b = 8'h00; 7'd60: b = 8'h42; 7'd61: b = 8'h00;
      7'd62: b = 8'h4C; 7'd63: b = 8'h00; 7'd64: b = 8'h43; 7'd65: b = 8'h00;
      7'd66: b = 8'h44; 7'd67: b = 8'h00;
      7'd68: b = 8'h0C; 7'd69: b = 8'h03; 7'd70: b = 8'h31; 7'd71: b = 8'h00;
      7'd72: b = 8'h36; 7'd73: b = 8'h00; 7'd74: b = 8'h30; 7'd75: b = 8'h00;
      7'd76: b = 8'h32; 7'd77: b = 8'h00; 7'd78: b = 8'h45; 7'd79: b = 8'h00;
      default: b = 8'h00;
    endcase
    rom_byte = b;
  endfunction

endpackage

[rtl/ucr_if.sv]
`timescale 1ns / 1ps
// ucr_evt_if / ucr_res_if: valid/ready channels for token events and result items
// no dependencies beyond the field widths fixed here

interface ucr_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [6:0] rx_length;
  logic [7:0] request_type;
  logic [7:0] request_code;
  logic [7:0] value_low;
  logic [7:0] value_high;
  logic [7:0] index_low;
  logic [7:0] length_low;
  logic [7:0] length_high;

  modport source (output valid, opcode, rx_length, request_type, request_code, value_low,
                  value_high, index_low, length_low, length_high, input ready);
  modport sink   (input valid, opcode, rx_length, request_type, request_code, value_low,
                  value_high, index_low, length_low, length_high, output ready);
endinterface

interface ucr_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] in_response;
  logic       out_response;
  logic       data_toggle;
  logic [6:0] tx_length;
  logic [7:0] payload_byte;
  logic       byte_valid;
  logic       last;
  logic [6:0] bus_address;

  modport source (output valid, in_response, out_response, data_toggle, tx_length,
                  payload_byte, byte_valid, last, bus_address, input ready);
  modport sink   (input valid, in_response, out_response, data_toggle, tx_length,
                  payload_byte, byte_valid, last, bus_address, output ready);
endinterface

[rtl/ucr_ram.sv]
`timescale 1ns / 1ps
// ucr_ram: generic single-port-write, single-port-read ram with registered read data
// no dependencies

module ucr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 80
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/usb_control_request_responder_core.sv]
`timescale 1ns / 1ps
// usb_control_request_responder_core: endpoint-0 standard request responder
// depends on ucr_pkg, ucr_evt_if / ucr_res_if and ucr_ram (descriptor store)
//
//  channel | direction | transfer                       | per event
//  evt_i   | in        | one token event (setup/in/out) | one
//  res_o   | out       | one packet byte or status item | 1 to MAX_PACKET, last marks the end
//
// an event is taken and its state update done in the same cycle; its results then stream
// through the read stage and the output register at one per cycle while res_o is not
// stalled, descriptor bytes coming from the descriptor ram
// the next event is taken once the final result of the previous one has gone out
// after reset the load state writes all 80 entries of the descriptor store; no event is taken meanwhile
// a stall on res_o holds the read stage and the output register, nothing is dropped

module usb_control_request_responder_core
  import ucr_pkg::*;
#(
  parameter int unsigned MAX_PACKET = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ucr_evt_if.sink     evt_i,
  ucr_res_if.source   res_o
);

  typedef enum logic [1:0] {ST_LOAD, ST_IDLE, ST_EMIT} state_e;

  localparam logic [6:0] MaxPkt     = 7'(MAX_PACKET);
  localparam logic [7:0] MaxPktByte = 8'(MAX_PACKET);
  localparam logic [RomAw-1:0] LoadEnd = RomAw'(RomSize - 1);

  state_e state_q;

  // protocol state
  logic [7:0] pend_q,  pend_d;
  logic [6:0] rem_q,   rem_d;
  logic [6:0] ptr_q,   ptr_d;
  logic [7:0] cfg_q,   cfg_d;
  logic [6:0] addr_q,  addr_d;
  logic       tog_q,   tog_d;
  logic [1:0] inhs_q,  inhs_d;
  logic       ouths_q, ouths_d;
  logic [6:0] plen_q,  plen_d;

  // stream set up by the event
  logic [6:0] n_d, start_d;
  logic       rom_d;
  logic [7:0] fb_d;
  logic [6:0] start_q, end_q, issued_q;
  logic       src_rom_q, status_q;
  logic [7:0] fb_q;

  logic [RomAw-1:0] load_idx_q;

  // descriptor lookup
  logic       dsc_ok;
  logic [6:0] dsc_base, dsc_len;

  // setup scratch
  logic [6:0] slen, drem, npk, len;
  logic       fail;

  // read stage and output register
  logic       s1_valid_q, s1_last_q, s1_first_q, s1_bv_q, s1_rom_q;
  logic       out_valid_q, out_bv_q, out_last_q;
  logic [7:0] out_byte_q;
  logic [7:0] ram_rdata, s1_byte;
  logic [7:0] addr_sum;
  logic       in_range, issue, s2_load, ram_re, ram_we;
  logic       evt_xfer;

  assign evt_i.ready = (state_q == ST_IDLE);
  assign evt_xfer    = evt_i.valid && evt_i.ready;

  always_comb begin
    dsc_ok   = 1'b1;
    dsc_base = DevBase;
    dsc_len  = DevLen;
    if (evt_i.value_high == DescDevice) begin
      dsc_base = DevBase;
      dsc_len  = DevLen;
    end else if (evt_i.value_high == DescConfig) begin
      dsc_base = CfgBase;
      dsc_len  = CfgLen;
    end else if (evt_i.value_high == DescString && evt_i.value_low == StrLang) begin
      dsc_base = LangBase;
      dsc_len  = LangLen;
    end else if (evt_i.value_high == DescString && evt_i.value_low == StrMfr) begin
      dsc_base = MfrBase;
      dsc_len  = MfrLen;
    end else if (evt_i.value_high == DescString && evt_i.value_low == StrProd) begin
      dsc_base = ProdBase;
      dsc_len  = ProdLen;
    end else begin
      dsc_ok = 1'b0;
    end
  end

  // next protocol state and the stream that the event produces
  always_comb begin
    pend_d  = pend_q;
    rem_d   = rem_q;
    ptr_d   = ptr_q;
    cfg_d   = cfg_q;
    addr_d  = addr_q;
    tog_d   = tog_q;
    inhs_d  = inhs_q;
    ouths_d = ouths_q;
    plen_d  = plen_q;
    n_d     = '0;
    start_d = ptr_q;
    rom_d   = 1'b0;
    fb_d    = '0;
    slen    = '0;
    drem    = '0;
    npk     = '0;
    len     = '0;
    fail    = 1'b0;

    case (evt_i.opcode)
      OpSetup: begin
        if (evt_i.rx_length != SetupLen) begin
          // malformed setup: stall, old packet length goes out as zero bytes
          pend_d  = NoRequest;
          inhs_d  = InStall;
          ouths_d = OutStall;
          tog_d   = 1'b1;
          n_d     = plen_q;
        end else begin
          slen = (evt_i.length_high != 8'd0 || evt_i.length_low > {1'b0, LenCap}) ?
                 LenCap : evt_i.length_low[6:0];
          pend_d = evt_i.request_code;
          if ((evt_i.request_type & TypeClassMask) != 8'd0) begin
            fail = 1'b1;
          end else begin
            case (evt_i.request_code)
              ReqGetDesc: begin
                if (dsc_ok) begin
                  drem    = min7(slen, dsc_len);
                  npk     = min7(drem, MaxPkt);
                  ptr_d   = dsc_base + npk;
                  slen    = drem - npk;
                  len     = npk;
                  rom_d   = 1'b1;
                  start_d = dsc_base;
                end else begin
                  fail = 1'b1;
                end
              end
              ReqSetAddress: slen = evt_i.value_low[6:0];
              ReqGetConfig: begin
                fb_d = cfg_q;
                len  = (slen != 7'd0) ? 7'd1 : 7'd0;
              end
              ReqSetConfig: cfg_d = evt_i.value_low;
              ReqClearFeature: begin
                if ((evt_i.request_type & TypeRecipMask) != RecipEndpoint ||
                    (evt_i.index_low != EpBulkIn && evt_i.index_low != EpBulkOut)) begin
                  fail = 1'b1;
                end
              end
              ReqGetInterface: len = (slen != 7'd0) ? 7'd1 : 7'd0;
              ReqGetStatus:    len = (slen >= 7'd2) ? 7'd2 : slen;
              default:         fail = 1'b1;
            endcase
          end
          rem_d = slen;
          if (fail) begin
            pend_d  = NoRequest;
            inhs_d  = InStall;
            ouths_d = OutStall;
            tog_d   = 1'b1;
            rom_d   = 1'b0;
            fb_d    = '0;
            n_d     = plen_q;
          end else begin
            plen_d  = len;
            inhs_d  = InAck;
            ouths_d = OutAck;
            tog_d   = 1'b1;
            n_d     = len;
          end
        end
      end
      OpIn: begin
        if (pend_q == ReqGetDesc) begin
          npk     = min7(rem_q, MaxPkt);
          rem_d   = rem_q - npk;
          ptr_d   = ptr_q + npk;
          plen_d  = npk;
          tog_d   = ~tog_q;
          rom_d   = 1'b1;
          start_d = ptr_q;
          n_d     = npk;
        end else begin
          // status stage: a pending set address takes effect here
          if (pend_q == ReqSetAddress) begin
            addr_d = rem_q;
          end else begin
            plen_d = '0;
          end
          inhs_d  = InNak;
          ouths_d = OutAck;
          tog_d   = 1'b0;
        end
      end
      OpOut: begin
        inhs_d  = InNak;
        ouths_d = OutAck;
        tog_d   = 1'b0;
      end
      OpBusReset: begin
        inhs_d  = InNak;
        ouths_d = OutAck;
        tog_d   = 1'b0;
        addr_d  = '0;
      end
      default: ;
    endcase
  end

  // result stream: read stage feeding the output register
  // a status item never carries descriptor data, even when the stream points into the store
  assign addr_sum = {1'b0, start_q} + {1'b0, issued_q};
  assign in_range = (addr_sum < 8'(RomSize));
  assign s2_load  = s1_valid_q && (!out_valid_q || res_o.ready);
  assign issue    = (state_q == ST_EMIT) && (issued_q != end_q) && (!s1_valid_q || s2_load);
  assign ram_re   = issue && src_rom_q && in_range && !status_q;
  assign ram_we   = (state_q == ST_LOAD);
  assign s1_byte  = s1_rom_q ? ram_rdata : ((s1_first_q && s1_bv_q) ? fb_q : 8'd0);

  ucr_ram #(
    .WIDTH (8),
    .DEPTH (RomSize)
  ) u_desc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (load_idx_q),
    .wdata_i ((load_idx_q == RomAw'(DevMaxPktIdx)) ? MaxPktByte :
              rom_byte(7'(load_idx_q))),
    .re_i    (ram_re),
    .raddr_i (addr_sum[RomAw-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      load_idx_q  <= '0;
      pend_q      <= NoRequest;
      rem_q       <= '0;
      ptr_q       <= '0;
      cfg_q       <= '0;
      addr_q      <= '0;
      tog_q       <= 1'b0;
      inhs_q      <= InNak;
      ouths_q     <= OutAck;
      plen_q      <= '0;
      issued_q    <= '0;
      end_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          load_idx_q <= load_idx_q + 1'b1;
          if (load_idx_q == LoadEnd) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (evt_xfer) begin
            pend_q    <= pend_d;
            rem_q     <= rem_d;
            ptr_q     <= ptr_d;
            cfg_q     <= cfg_d;
            addr_q    <= addr_d;
            tog_q     <= tog_d;
            inhs_q    <= inhs_d;
            ouths_q   <= ouths_d;
            plen_q    <= plen_d;
            start_q   <= start_d;
            src_rom_q <= rom_d;
            fb_q      <= fb_d;
            status_q  <= (n_d == 7'd0);
            end_q     <= (n_d == 7'd0) ? 7'd1 : n_d;
            issued_q  <= '0;
            state_q   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_valid_q && res_o.ready && out_last_q) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_LOAD;
      endcase

      if (issue) begin
        issued_q   <= issued_q + 1'b1;
        s1_valid_q <= 1'b1;
        s1_last_q  <= (issued_q == end_q - 7'd1);
        s1_first_q <= (issued_q == 7'd0);
        s1_bv_q    <= !status_q;
        s1_rom_q   <= src_rom_q && in_range && !status_q;
      end else if (s2_load) begin
        s1_valid_q <= 1'b0;
      end

      if (s2_load) begin
        out_valid_q <= 1'b1;
        out_byte_q  <= s1_byte;
        out_bv_q    <= s1_bv_q;
        out_last_q  <= s1_last_q;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.in_response  = inhs_q;
  assign res_o.out_response = ouths_q;
  assign res_o.data_toggle  = tog_q;
  assign res_o.tx_length    = plen_q;
  assign res_o.payload_byte = out_byte_q;
  assign res_o.byte_valid   = out_bv_q;
  assign res_o.last         = out_last_q;
  assign res_o.bus_address  = addr_q;

  // results only belong to an event in progress
  a_out_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> state_q == ST_EMIT)
    else $error("result presented outside of an event");

  // a new event never lands on a stream still in flight
  a_evt_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_xfer |-> !s1_valid_q && !out_valid_q)
    else $error("event taken with results still in flight");

  // never issue more reads than the event announced
  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> issued_q <= end_q)
    else $error("stream counter ran past its end");

  // descriptor reads stay inside the store
  a_ram_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> addr_sum < 8'(RomSize))
    else $error("descriptor read out of range");

  // a status-only item is always the final one of its event
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.byte_valid |-> res_o.last)
    else $error("status item not marked last");

endmodule
